FILE: sv/f2gpd_pkg.sv
package f2gpd_pkg;

    localparam int MAX_INDIVIDUALS = 256;
    localparam int MAX_MARKERS     = 1024;
    localparam int PROB_FRAC_BITS  = 15;

    localparam int IND_W   = $clog2(MAX_INDIVIDUALS);
    localparam int MRK_W   = $clog2(MAX_MARKERS);
    localparam int ADDR_W  = IND_W + MRK_W;
    localparam int PROB_W  = 16;
    localparam int ENTRY_W = 3 * PROB_W + 1;

    localparam int CFG_IND_W = 9;
    localparam int CFG_MRK_W = 11;
    localparam int CNT_W     = 11;

    // Sum of one marker is below 16 * 2^(2*FRAC); over all markers add MRK_W bits.
    localparam int PROD_W = 2 * PROB_W + 1;
    localparam int SUM_W  = 2 * PROB_FRAC_BITS + 4 + MRK_W;
    localparam int ROOT_IN_W = 2 * PROB_FRAC_BITS + 2;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1 << PROB_FRAC_BITS);

    localparam logic [0:0] OP_WRITE = 1'b0;
    localparam logic [0:0] OP_QUERY = 1'b1;

    localparam logic [0:0] REG_INDIVIDUALS = 1'b0;
    localparam logic [0:0] REG_MARKERS     = 1'b1;

    typedef struct packed {
        logic [PROB_W-1:0] p1;
        logic [PROB_W-1:0] p2;
        logic [PROB_W-1:0] p3;
        logic              miss;
    } entry_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

endpackage

FILE: sv/f2gpd_store.sv
module f2gpd_store (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [f2gpd_pkg::ADDR_W-1:0] wr_addr,
    input  f2gpd_pkg::entry_t          wr_data,
    input  logic [f2gpd_pkg::ADDR_W-1:0] rd_addr,
    output f2gpd_pkg::entry_t          rd_data
);

    localparam int DEPTH = 1 << f2gpd_pkg::ADDR_W;

    f2gpd_pkg::entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/f2gpd_divsqrt.sv
// Restoring divider followed by a bit-pair square root, one step a cycle.
module f2gpd_divsqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [f2gpd_pkg::SUM_W-1:0]   sum,
    input  logic [f2gpd_pkg::CNT_W-1:0]   count,
    output logic                          done,
    output logic [f2gpd_pkg::PROB_W-1:0]  root
);

    localparam int SW = f2gpd_pkg::SUM_W;
    localparam int DW = f2gpd_pkg::CNT_W + 1;
    localparam int RW = f2gpd_pkg::ROOT_IN_W;
    localparam int HW = RW / 2;
    localparam logic [RW-1:0] ONE_SQ = RW'(1) << (2 * f2gpd_pkg::PROB_FRAC_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [6:0]       step_reg, step_next;
    logic [SW-1:0]    quo_reg, quo_next;
    logic [DW:0]      rem_reg, rem_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [RW-1:0]    rad_reg, rad_next;
    logic [HW+1:0]    srem_reg, srem_next;
    logic [HW-1:0]    res_reg, res_next;

    logic [DW:0]      shifted;
    logic [HW+1:0]    trial;
    logic [HW+1:0]    stry;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        rad_next   = rad_reg;
        srem_next  = srem_reg;
        res_next   = res_reg;
        shifted    = '0;
        trial      = '0;
        stry       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    quo_next   = sum;
                    rem_next   = '0;
                    den_next   = {count, 1'b0};
                    step_next  = 7'(SW - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                shifted  = {rem_reg[DW-1:0], quo_reg[SW-1]};
                quo_next = {quo_reg[SW-2:0], 1'b0};
                if (shifted >= {1'b0, den_reg}) begin
                    rem_next    = shifted - {1'b0, den_reg};
                    quo_next[0] = 1'b1;
                end else begin
                    rem_next = shifted;
                end
                if (step_reg == '0) begin
                    if (quo_next >= SW'(ONE_SQ)) begin
                        rad_next = '0;
                    end else begin
                        rad_next = ONE_SQ - RW'(quo_next);
                    end
                    srem_next  = '0;
                    res_next   = '0;
                    step_next  = 7'(HW - 1);
                    state_next = ST_SQRT;
                end else begin
                    step_next = step_reg - 7'd1;
                end
            end
            ST_SQRT: begin
                stry     = {srem_reg[HW-1:0], rad_reg[RW-1:RW-2]};
                trial    = {res_reg, 2'b01};
                rad_next = {rad_reg[RW-3:0], 2'b00};
                if (stry >= trial) begin
                    srem_next = stry - trial;
                    res_next  = {res_reg[HW-2:0], 1'b1};
                end else begin
                    srem_next = stry;
                    res_next  = {res_reg[HW-2:0], 1'b0};
                end
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg - 7'd1;
                end
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        res_reg  <= res_next;
    end

    assign done = (state_reg == ST_DONE);
    // The root of a value up to one in Q2.30 fits 16 bits at this precision.
    assign root = (HW > f2gpd_pkg::PROB_W && |res_reg[HW-1:f2gpd_pkg::PROB_W-1] &&
                   res_reg > HW'(16'hFFFF)) ? 16'hFFFF : f2gpd_pkg::PROB_W'(res_reg);

endmodule

FILE: sv/f2gpd_mac.sv
// One shared multiplier, driven through seven product terms per marker.
module f2gpd_mac (
    input  logic                         aclk,
    input  logic                         clear,
    input  logic                         acc_en,
    input  logic [2:0]                   term,
    input  f2gpd_pkg::entry_t            ent_a,
    input  f2gpd_pkg::entry_t            ent_b,
    output logic [f2gpd_pkg::SUM_W-1:0]  sum
);

    logic [f2gpd_pkg::PROB_W-1:0] op_x, op_y;
    logic                         dbl;
    logic [f2gpd_pkg::PROD_W-1:0] prod;
    logic [f2gpd_pkg::SUM_W-1:0]  sum_reg;

    always_comb begin
        op_x = ent_a.p1;
        op_y = ent_b.p1;
        dbl  = 1'b0;
        case (term)
            3'd0: begin op_x = ent_a.p1; op_y = ent_b.p1; dbl = 1'b1; end
            3'd1: begin op_x = ent_a.p2; op_y = ent_b.p2; dbl = 1'b1; end
            3'd2: begin op_x = ent_a.p3; op_y = ent_b.p3; dbl = 1'b1; end
            3'd3: begin op_x = ent_a.p1; op_y = ent_b.p2; end
            3'd4: begin op_x = ent_b.p1; op_y = ent_a.p2; end
            3'd5: begin op_x = ent_a.p2; op_y = ent_b.p3; end
            3'd6: begin op_x = ent_b.p2; op_y = ent_a.p3; end
            default: begin op_x = '0; op_y = '0; end
        endcase
        prod = f2gpd_pkg::PROD_W'(op_x * op_y) << dbl;
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            sum_reg <= '0;
        end else if (acc_en) begin
            sum_reg <= sum_reg + f2gpd_pkg::SUM_W'(prod);
        end
    end

    assign sum = sum_reg;

endmodule

FILE: sv/f2_genotype_prob_distance.sv
// Writes: a write is stored in the cycle after its transfer; the next item waits until then.
// Queries: per marker in use, two store reads, a wait and seven shared multiply-accumulate
// steps, then a 44-step divider and a 16-step root; with no shared marker both are skipped, and
// a pair not in use reads no store entry. Throughput: one item at a time; s_tready stays low
// from acceptance until the write is stored or the result transfer completes. Reset (aresetn,
// synchronous, active low) restores 256 individuals and 1024 markers.
module f2_genotype_prob_distance (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: opcode, individual, other_individual, marker, prob_first, prob_het,
    // prob_second, missing, zero padding (bits 79:76)
    input  logic [79:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: distance, no_shared_markers, shared_count, zero padding (bits 31:28)
    output logic [31:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_TERM  = 3'd4;
    localparam logic [2:0] ST_ROOT  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;
    localparam logic [2:0] ST_START = 3'd7;

    localparam int IW = f2gpd_pkg::IND_W;
    localparam int MW = f2gpd_pkg::MRK_W;

    logic [2:0]  state_reg, state_next;
    logic [f2gpd_pkg::CFG_IND_W-1:0] inds_reg;
    logic [f2gpd_pkg::CFG_MRK_W-1:0] mrks_reg;

    // Fields of the accepted item.
    logic [0:0]  in_op;
    logic [7:0]  in_ia, in_ib;
    logic [9:0]  in_mk;
    logic [15:0] in_p1, in_p2, in_p3;
    logic        in_miss;

    assign in_op   = s_tdata[0:0];
    assign in_ia   = s_tdata[8:1];
    assign in_ib   = s_tdata[16:9];
    assign in_mk   = s_tdata[26:17];
    assign in_p1   = s_tdata[42:27];
    assign in_p2   = s_tdata[58:43];
    assign in_p3   = s_tdata[74:59];
    assign in_miss = s_tdata[75];

    function automatic logic [15:0] sat_prob(input logic [15:0] v);
        sat_prob = (v > f2gpd_pkg::PROB_ONE) ? f2gpd_pkg::PROB_ONE : v;
    endfunction

    logic [IW-1:0]      ia_reg, ib_reg;
    logic [MW:0]        mk_reg;          // marker cursor, one bit wider for the limit
    logic [MW:0]        limit_reg;
    logic               side_reg;        // which row is being read
    logic [2:0]         term_reg;
    f2gpd_pkg::entry_t  ent_a_reg;
    logic [f2gpd_pkg::CNT_W-1:0] cnt_reg;
    logic [15:0]        dist_reg;
    logic               wr_en_reg;
    logic [f2gpd_pkg::ADDR_W-1:0] wr_addr_reg;
    f2gpd_pkg::entry_t  wr_data_reg;

    f2gpd_pkg::entry_t  rd_data;
    logic [f2gpd_pkg::ADDR_W-1:0] rd_addr;
    logic [f2gpd_pkg::SUM_W-1:0]  sum;
    logic               ds_done;
    logic [15:0]        root;
    f2gpd_pkg::unit_ctl_t mac_ctl;
    logic               ds_start;

    logic s_fire;
    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    assign rd_addr = {side_reg ? ib_reg : ia_reg, mk_reg[MW-1:0]};

    f2gpd_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (wr_data_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The multiplier accumulates when both entries of the marker are present.
    always_comb begin
        mac_ctl.start = s_fire && (in_op == f2gpd_pkg::OP_QUERY);
        mac_ctl.busy  = (state_reg == ST_TERM) && !ent_a_reg.miss && !rd_data.miss;
        mac_ctl.done  = 1'b0;
    end

    f2gpd_mac u_mac (
        .aclk   (aclk),
        .clear  (mac_ctl.start),
        .acc_en (mac_ctl.busy),
        .term   (term_reg),
        .ent_a  (ent_a_reg),
        .ent_b  (rd_data),
        .sum    (sum)
    );

    f2gpd_divsqrt u_ds (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ds_start),
        .sum     (sum),
        .count   (cnt_reg),
        .done    (ds_done),
        .root    (root)
    );

    always_comb begin
        state_next = state_reg;
        ds_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (in_op == f2gpd_pkg::OP_WRITE) begin
                        state_next = ST_WRITE;
                    end else if ({1'b0, in_ia} >= inds_reg || {1'b0, in_ib} >= inds_reg ||
                                 mrks_reg == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_WRITE: state_next = ST_IDLE;
            // Read row a, latch it, then read row b and walk the seven terms.
            ST_READ:  state_next = ST_WAIT;
            ST_WAIT:  state_next = side_reg ? ST_TERM : ST_WAIT;
            ST_TERM: begin
                if (term_reg == 3'd6) begin
                    if (mk_reg + 1'b1 >= limit_reg) begin
                        if ((cnt_reg != '0) || (!ent_a_reg.miss && !rd_data.miss)) begin
                            state_next = ST_START;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            // The last product and the last count land at the same edge, so the
            // divider is started in the cycle after, from ST_START, with the finished sum and count.
            ST_START: begin
                ds_start   = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:  state_next = ds_done ? ST_OUT : ST_ROOT;
            ST_OUT:   state_next = m_tready ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            inds_reg  <= 9'd256;
            mrks_reg  <= 11'd1024;
            wr_en_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            wr_en_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    f2gpd_pkg::REG_INDIVIDUALS: inds_reg <= cfg_data[8:0];
                    f2gpd_pkg::REG_MARKERS:     mrks_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end
            if (s_fire && in_op == f2gpd_pkg::OP_WRITE) begin
                wr_en_reg <= 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                wr_addr_reg      <= {in_ia[IW-1:0], in_mk[MW-1:0]};
                wr_data_reg.p1   <= sat_prob(in_p1);
                wr_data_reg.p2   <= sat_prob(in_p2);
                wr_data_reg.p3   <= sat_prob(in_p3);
                wr_data_reg.miss <= in_miss;
                ia_reg   <= in_ia[IW-1:0];
                ib_reg   <= in_ib[IW-1:0];
                mk_reg   <= '0;
                side_reg <= 1'b0;
                term_reg <= '0;
                cnt_reg  <= '0;
                dist_reg <= '0;
                limit_reg <= (mrks_reg > (MW+1)'(f2gpd_pkg::MAX_MARKERS)) ?
                             (MW+1)'(f2gpd_pkg::MAX_MARKERS) : (MW+1)'(mrks_reg);
            end
            ST_READ: begin
                // Address of row a is presented now; switch to row b next.
            end
            ST_WAIT: begin
                if (!side_reg) begin
                    ent_a_reg <= rd_data;
                    side_reg  <= 1'b1;
                end
            end
            ST_TERM: begin
                if (term_reg == 3'd6) begin
                    term_reg <= '0;
                    side_reg <= 1'b0;
                    mk_reg   <= mk_reg + 1'b1;
                    if (!ent_a_reg.miss && !rd_data.miss) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end else begin
                    term_reg <= term_reg + 3'd1;
                end
            end
            ST_ROOT: begin
                if (ds_done) dist_reg <= root;
            end
            default: ;
        endcase
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {4'b0, cnt_reg, (cnt_reg == '0), dist_reg};

endmodule

FILE: dv/testbench.sv
module testbench;
    import f2gpd_pkg::*;

    // Result of one pair query, laid out as the result tdata, highest field first.
    typedef struct packed {
        logic [CNT_W-1:0] shared_count;
        logic             no_shared;
        logic [15:0]      distance;
    } pair_result_t;

    localparam int IDLE_LIMIT = 40000;
    localparam int HOLD_CYCLES = 400;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [15:0]  cfg_data;
    logic         hold_req;

    // Our own view of the block: its registers and every entry written so far.
    entry_t                 geno_store [int];
    logic [CFG_IND_W-1:0]   shadow_individuals;
    logic [CFG_MRK_W-1:0]   shadow_markers;
    pair_result_t           expected_distances [$];

    int mismatches;
    int write_count;
    int query_count;
    int no_shared_count;
    int zero_distance_count;
    int result_count;
    int burst_left;
    int idle_cycles;

    f2_genotype_prob_distance i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Integer square root, rounded down, built one result bit at a time.
    function automatic logic [31:0] floor_root(input logic [63:0] x);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // True when every marker summed for this individual has been written, so
    // a query never touches an entry whose contents are undefined.
    function automatic bit row_ready(input int ind, input int nm);
        for (int m = 0; m < nm; m++) begin
            if (!geno_store.exists(ind * MAX_MARKERS + m)) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic int markers_summed();
        return (shadow_markers > MAX_MARKERS) ? MAX_MARKERS : int'(shadow_markers);
    endfunction

    function automatic bit pair_in_use(input int a, input int b);
        return (a < shadow_individuals) && (b < shadow_individuals);
    endfunction

    function automatic logic [PROB_W-1:0] clip_prob(input logic [PROB_W-1:0] p);
        return (p > PROB_ONE) ? PROB_ONE : p;
    endfunction

    // Weighted overlap of the two rows, then sqrt(1 - S/(2C)) saturated at zero.
    function automatic pair_result_t pair_distance(input int a, input int b);
        pair_result_t r;
        logic [63:0]  total;
        logic [63:0]  quotient;
        logic [63:0]  remainder;
        logic [63:0]  f1, h1, s1, f2, h2, s2;
        logic [31:0]  root;
        int           shared;
        entry_t       x;
        entry_t       y;
        total = '0;
        shared = 0;
        if (pair_in_use(a, b)) begin
            for (int m = 0; m < markers_summed(); m++) begin
                x = geno_store[a * MAX_MARKERS + m];
                y = geno_store[b * MAX_MARKERS + m];
                if (!x.miss && !y.miss) begin
                    f1 = x.p1; h1 = x.p2; s1 = x.p3;
                    f2 = y.p1; h2 = y.p2; s2 = y.p3;
                    total += 2 * (f1 * f2 + h1 * h2 + s1 * s2)
                             + f1 * h2 + f2 * h1 + h1 * s2 + h2 * s1;
                    shared++;
                end
            end
        end
        r.distance = '0;
        if (shared != 0) begin
            quotient = total / (64'd2 * 64'(shared));
            remainder = (quotient >= (64'd1 << (2 * PROB_FRAC_BITS))) ? 64'd0
                        : (64'd1 << (2 * PROB_FRAC_BITS)) - quotient;
            root = floor_root(remainder);
            r.distance = (root > 32'hFFFF) ? 16'hFFFF : root[15:0];
        end
        r.no_shared = (shared == 0);
        r.shared_count = CNT_W'(shared);
        return r;
    endfunction

    // Probabilities lean towards the legal range but also hit one exactly, zero
    // and values above one that the block must clip.
    function automatic logic [PROB_W-1:0] pick_prob();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return PROB_ONE;
            2: return PROB_W'($urandom_range(32769, 65535));
            default: return PROB_W'($urandom_range(0, 32768));
        endcase
    endfunction

    // Sender: one transfer on the input channel. Bursts of random length are
    // mostly separated by random gaps; inside a burst tvalid stays high throughout.
    task automatic send_item(input logic [0:0] op, input logic [7:0] ind,
                             input logic [7:0] other, input logic [9:0] mk,
                             input logic [PROB_W-1:0] pf, input logic [PROB_W-1:0] ph,
                             input logic [PROB_W-1:0] ps, input logic miss);
        entry_t e;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, miss, ps, ph, pf, mk, other, ind, op};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_WRITE) begin
            e.p1 = clip_prob(pf);
            e.p2 = clip_prob(ph);
            e.p3 = clip_prob(ps);
            e.miss = miss;
            geno_store[int'(ind) * MAX_MARKERS + int'(mk)] = e;
            write_count++;
        end else begin
            expected_distances.push_back(pair_distance(ind, other));
            query_count++;
        end
    endtask

    task automatic write_entry(input int ind, input int mk, input logic [PROB_W-1:0] pf,
                               input logic [PROB_W-1:0] ph, input logic [PROB_W-1:0] ps,
                               input logic miss);
        send_item(OP_WRITE, 8'(ind), 8'($urandom), 10'(mk), pf, ph, ps, miss);
    endtask

    // On a query the marker and probability fields carry random junk.
    task automatic query_pair(input int a, input int b);
        send_item(OP_QUERY, 8'(a), 8'(b), 10'($urandom), PROB_W'($urandom),
                  PROB_W'($urandom), PROB_W'($urandom), 1'($urandom));
    endtask

    // Stop offering items and wait until every expected result has been seen,
    // then let a write that gives no result finish inside the block.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_distances.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(input logic [0:0] index, input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= 16'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_INDIVIDUALS) begin
            shadow_individuals = CFG_IND_W'(value);
        end else begin
            shadow_markers = CFG_MRK_W'(value);
        end
    endtask

    // Individuals 0 to 7 get markers 0 to 15, so that random queries among
    // them are always legal while at most sixteen markers are summed.
    task automatic test_fill_pool();
        for (int i = 0; i < 8; i++) begin
            for (int m = 0; m < 16; m++) begin
                write_entry(i, m, pick_prob(), pick_prob(), pick_prob(),
                            $urandom_range(0, 5) == 0);
            end
        end
    endtask

    // Hand-built rows for the corner cases, summed over four markers.
    task automatic test_corners();
        write_register(REG_MARKERS, 4);
        for (int m = 0; m < 4; m++) begin
            write_entry(8, m, PROB_ONE, 16'd0, 16'd0, 1'b1);       // always missing
            write_entry(9, m, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0); // clipped to one
            write_entry(10, m, PROB_ONE, 16'd0, 16'd0, 1'b0);
            write_entry(11, m, 16'd0, 16'd0, PROB_ONE, 1'b0);
        end
        query_pair(8, 0);   // no marker is shared
        query_pair(9, 9);   // overlap above one, distance saturates at zero
        query_pair(10, 11); // opposite homozygotes, distance of one
        query_pair(10, 10); // identical rows, distance of zero
        query_pair(3, 5);
        write_register(REG_INDIVIDUALS, 1);
        query_pair(0, 0);
        query_pair(0, 1);   // second individual is not in use
        query_pair(255, 0);
        write_register(REG_INDIVIDUALS, 0);
        query_pair(0, 0);   // nobody is in use
        write_register(REG_INDIVIDUALS, 256);
        write_register(REG_MARKERS, 0);
        query_pair(2, 2);   // no markers are summed at all
        query_pair(10, 11);
        drain();
    endtask

    // One long row on the last individual, walked over many markers.
    task automatic test_full_row();
        write_register(REG_MARKERS, 200);
        for (int m = 0; m < 200; m++) begin
            write_entry(255, m, pick_prob(), pick_prob(), pick_prob(),
                        $urandom_range(0, 7) == 0);
        end
        query_pair(255, 255);
        write_register(REG_INDIVIDUALS, 255);
        query_pair(255, 0); // not in use, so nothing is read
        query_pair(0, 255);
        drain();
    endtask

    // Mostly queries within the prepared rows, mixed with overwrites of those
    // rows and with stray writes and queries that reach every field bit.
    task automatic test_random_phase(input int individuals, input int markers,
                                     input int count, input bit squeeze);
        int a;
        int b;
        write_register(REG_INDIVIDUALS, individuals);
        write_register(REG_MARKERS, markers);
        for (int n = 0; n < count; n++) begin
            if (squeeze && n == count / 2) begin
                // The receiver holds off for a long stretch while we keep offering.
                hold_req <= 1'b1;
                @(posedge aclk);
                hold_req <= 1'b0;
            end
            if (n == count / 3) begin
                drain();
            end
            case ($urandom_range(0, 9))
                0, 1, 2: write_entry($urandom_range(0, 7), $urandom_range(0, 15),
                                     pick_prob(), pick_prob(), pick_prob(),
                                     $urandom_range(0, 4) == 0);
                3: write_entry($urandom_range(16, 254), $urandom_range(0, 1023),
                               pick_prob(), pick_prob(), pick_prob(), 1'($urandom));
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        a = $urandom_range(0, 255);
                        b = $urandom_range(0, 255);
                    end else begin
                        a = $urandom_range(0, 7);
                        b = $urandom_range(0, 7);
                    end
                    if (pair_in_use(a, b) && !(row_ready(a, markers_summed())
                                               && row_ready(b, markers_summed()))) begin
                        a = $urandom_range(0, 7);
                        b = $urandom_range(0, 7);
                    end
                    query_pair(a, b);
                end
            endcase
        end
        drain();
    endtask

    // Receiver: switches between always ready, random stalls and sparse
    // readiness, and obeys a long hold-off when asked.
    int rx_cycle;
    int hold_left;
    int stall_mode;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_cycle <= 0;
            hold_left <= 0;
            stall_mode <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0) begin
                stall_mode <= $urandom_range(0, 2);
            end
            if (hold_req) begin
                hold_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Checker: every result transfer is held against the oldest expectation.
    pair_result_t got;
    pair_result_t want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[27:0];
            result_count++;
            if (expected_distances.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result transfer: distance %0d flag %0d count %0d",
                             got.distance, got.no_shared, got.shared_count);
                end
            end else begin
                want = expected_distances.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected distance %0d flag %0d count %0d, got %0d %0d %0d",
                                 want.distance, want.no_shared, want.shared_count,
                                 got.distance, got.no_shared, got.shared_count);
                    end
                end else begin
                    if (want.no_shared) no_shared_count++;
                    else if (want.distance == 0) zero_distance_count++;
                end
            end
        end
    end

    // Watchdog: the run is stuck if no channel moves for a long time. The
    // slowest legal gap is one query over the longest row plus a hold-off.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 1'b0;
        shadow_individuals = CFG_IND_W'(256);
        shadow_markers = CFG_MRK_W'(1024);
        mismatches = 0;
        write_count = 0;
        query_count = 0;
        no_shared_count = 0;
        zero_distance_count = 0;
        result_count = 0;
        burst_left = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fill_pool();
        test_corners();
        test_full_row();
        test_random_phase(256, 16, 50, 1'b1);
        test_random_phase(511, 8, 40, 1'b0);
        test_random_phase(3, 1, 30, 1'b0);
        test_random_phase(20, 12, 40, 1'b1);
        test_random_phase(6, 5, 40, 1'b0);
        drain();
        repeat (40) @(posedge aclk);

        $display("Covered %0d writes and %0d queries; %0d results checked.",
                 write_count, query_count, result_count);
        $display("Queries without shared markers: %0d, saturated at zero: %0d.",
                 no_shared_count, zero_distance_count);
        if (mismatches == 0 && expected_distances.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
